### sv/hcbd_pkg.sv
// shared types, constants and helpers for the chunked body decoder
// no dependencies; compiled before the interfaces and modules
package hcbd_pkg;

  localparam int LEN_BITS   = 32;
  localparam int HEX_RADIX  = 16;
  localparam int DIGIT_BITS = $clog2(HEX_RADIX);
  localparam int KIND_BITS  = 2;

  localparam logic [7:0] LF_CHAR = 8'h0A;

  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_FRAMING = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  // input register contents handed to the decode core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic                  ok;
    logic [DIGIT_BITS-1:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = DIGIT_BITS'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = DIGIT_BITS'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = DIGIT_BITS'(c - 8'h41 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### sv/hcbd_if.sv
// valid/ready channel interfaces for raw body bytes and decoded results
// depends on hcbd_pkg for the kind field width
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     out_byte;
  logic [hcbd_pkg::KIND_BITS-1:0] kind;
  logic                           chunk_last;
  logic                           size_overflow;

  modport source (output valid, output out_byte, output kind, output chunk_last,
                  output size_overflow, input ready);
  modport sink   (input valid, input out_byte, input kind, input chunk_last,
                  input size_overflow, output ready);
endinterface

### sv/hcbd_in_reg.sv
// input register: holds one raw byte until the decode core takes it
// depends on hcbd_pkg and hcbd_in_if
module hcbd_in_reg (
  input  logic             clk,
  input  logic             rst,
  hcbd_in_if.sink          in_ch,
  input  logic             take,
  output hcbd_pkg::stage_t stg
);

  logic       valid;
  logic       valid_next;
  logic [7:0] data;
  logic       accept;

  // a new item may enter as the held one leaves
  assign in_ch.ready = !valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    if (accept) begin
      data <= in_ch.in_byte;
    end
  end

  assign stg.valid = valid;
  assign stg.data  = data;

endmodule

### sv/hcbd_core.sv
// decode core: framing state, chunk counters and the result register
// depends on hcbd_pkg and hcbd_out_if
module hcbd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  input  hcbd_pkg::stage_t stg,
  output logic             take,
  hcbd_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_BODY = 2'd1,
    PH_END  = 2'd2
  } phase_t;

  phase_t         phase, phase_next;
  logic           hex_done, hex_done_next;
  hcbd_pkg::len_t size_accum, size_accum_next;
  hcbd_pkg::len_t bytes_left, bytes_left_next;
  logic           chunk_was_empty, chunk_was_empty_next;
  logic           line_overflow, line_overflow_next;
  logic           discard_payload;

  logic            res_valid;
  logic [7:0]      res_byte, res_byte_next;
  hcbd_pkg::kind_t res_kind, res_kind_next;
  logic            res_last, res_last_next;
  logic            res_ovf, res_ovf_next;

  hcbd_pkg::hex_digit_t digit;
  hcbd_pkg::len_t       left_dec;
  logic                 is_lf;

  assign take     = stg.valid && (!res_valid || out_ch.ready);
  assign digit    = hcbd_pkg::hex_value(stg.data);
  assign left_dec = bytes_left - hcbd_pkg::len_t'(1);
  assign is_lf    = stg.data == hcbd_pkg::LF_CHAR;

  always_comb begin
    phase_next           = phase;
    hex_done_next        = hex_done;
    size_accum_next      = size_accum;
    bytes_left_next      = bytes_left;
    chunk_was_empty_next = chunk_was_empty;
    line_overflow_next   = line_overflow;
    res_byte_next        = 8'h00;
    res_kind_next        = hcbd_pkg::KIND_FRAMING;
    res_last_next        = 1'b0;
    res_ovf_next         = 1'b0;
    case (phase)
      PH_BODY: begin
        if (bytes_left == '0) begin
          phase_next = PH_END;
        end else begin
          bytes_left_next = left_dec;
          if (!discard_payload) begin
            res_kind_next = hcbd_pkg::KIND_PAYLOAD;
            res_byte_next = stg.data;
          end
          if (left_dec == '0) begin
            res_last_next = 1'b1;
            phase_next    = PH_END;
          end
        end
      end
      PH_END: begin
        if (is_lf) begin
          if (chunk_was_empty) begin
            res_kind_next        = hcbd_pkg::KIND_DONE;
            chunk_was_empty_next = 1'b0;
          end
          phase_next         = PH_SIZE;
          hex_done_next      = 1'b0;
          size_accum_next    = '0;
          line_overflow_next = 1'b0;
        end
      end
      default: begin
        // size line, also reached from the unused phase code
        phase_next = PH_SIZE;
        if (is_lf) begin
          res_ovf_next = line_overflow;
          if (size_accum == '0) begin
            chunk_was_empty_next = 1'b1;
            bytes_left_next      = '0;
            phase_next           = PH_END;
          end else begin
            chunk_was_empty_next = 1'b0;
            bytes_left_next      = size_accum;
            phase_next           = PH_BODY;
          end
          hex_done_next      = 1'b0;
          size_accum_next    = '0;
          line_overflow_next = 1'b0;
        end else begin
          if (hex_done || !digit.ok) begin
            hex_done_next = 1'b1;
          end else if (size_accum[hcbd_pkg::LEN_BITS-1 -: hcbd_pkg::DIGIT_BITS] != '0) begin
            // next digit would shift bits out: saturate
            size_accum_next    = '1;
            line_overflow_next = 1'b1;
          end else begin
            size_accum_next = {size_accum[hcbd_pkg::LEN_BITS-hcbd_pkg::DIGIT_BITS-1:0],
                               digit.val};
          end
          res_ovf_next = line_overflow_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      hex_done        <= 1'b0;
      size_accum      <= '0;
      bytes_left      <= '0;
      chunk_was_empty <= 1'b0;
      line_overflow   <= 1'b0;
      discard_payload <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        discard_payload <= cfg_data;
      end
      if (take) begin
        phase           <= phase_next;
        hex_done        <= hex_done_next;
        size_accum      <= size_accum_next;
        bytes_left      <= bytes_left_next;
        chunk_was_empty <= chunk_was_empty_next;
        line_overflow   <= line_overflow_next;
        res_valid       <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (take) begin
      res_byte <= res_byte_next;
      res_kind <= res_kind_next;
      res_last <= res_last_next;
      res_ovf  <= res_ovf_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.out_byte      = res_byte;
  assign out_ch.kind          = res_kind;
  assign out_ch.chunk_last    = res_last;
  assign out_ch.size_overflow = res_ovf;

`ifndef SYNTHESIS
  a_last_on_final_byte: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_BODY && bytes_left == hcbd_pkg::len_t'(1)
      |=> res_valid && res_last && phase == PH_END)
    else $error("final payload byte of a chunk not marked");

  a_empty_chunk: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_SIZE && is_lf && size_accum == '0
      |=> phase == PH_END && chunk_was_empty)
    else $error("zero-size chunk did not arm message completion");

  a_counter_holds: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(bytes_left) && $stable(phase))
    else $error("decode state moved without an item");

  a_last_not_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_kind != hcbd_pkg::KIND_DONE)
    else $error("chunk end flagged on a completion result");
`endif

endmodule

### sv/http_chunked_body_decoder_unit.sv
// chunked body decoder: input register, decode core, result register
// an accepted byte waits in the input register, then its result in the result register
// throughput: one byte per cycle while the receiver takes each result; the core state updates as each byte is taken
// the input register takes one new byte while the previous result waits
// reset (rst, synchronous): size-line phase, counters cleared, discard_payload 0
module http_chunked_body_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch
);

  hcbd_pkg::stage_t stg;
  logic             take;

  hcbd_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .take  (take),
    .stg   (stg)
  );

  hcbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .stg       (stg),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

### tb/tb_http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// testbench for http_chunked_body_decoder_unit: directed and random chunked bodies,
// checked item by item against its own byte-level decode; needs hcbd_pkg and hcbd_if
module tb_http_chunked_body_decoder_unit;

  typedef enum logic [1:0] {
    ST_SIZE_LINE,
    ST_PAYLOAD,
    ST_LINE_END
  } parse_state_t;

  typedef struct packed {
    logic [7:0]      data;
    hcbd_pkg::kind_t kind;
    logic            chunk_end;
    logic            ovf;
  } decoded_t;

  localparam hcbd_pkg::len_t LEN_MAX = '1;
  localparam logic [7:0]     CR_CHAR = 8'h0D;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  hcbd_in_if  in_ch ();
  hcbd_out_if out_ch ();

  http_chunked_body_decoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // decoder shadow state
  parse_state_t   st          = ST_SIZE_LINE;
  bit             digits_done = 1'b0;
  hcbd_pkg::len_t size_acc    = '0;
  hcbd_pkg::len_t bytes_left  = '0;
  bit             zero_chunk  = 1'b0;
  bit             line_ovf    = 1'b0;
  bit             discard_mode = 1'b0;

  decoded_t decoded_bytes[$];

  int  bytes_sent  = 0;
  int  n_errors    = 0;
  int  n_payload   = 0;
  int  n_complete  = 0;
  int  n_ovf       = 0;
  bit  tx_idle     = 1'b1;
  bit  rx_idle     = 1'b1;
  int  rx_hold_len = 0;
  bit  rx_holding  = 1'b0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic decoded_t decode_byte(input logic [7:0] b);
    decoded_t r;
    int       d;
    r.data      = 8'h00;
    r.kind      = hcbd_pkg::KIND_FRAMING;
    r.chunk_end = 1'b0;
    r.ovf       = 1'b0;
    case (st)
      ST_PAYLOAD: begin
        if (bytes_left == 0) begin
          st = ST_LINE_END;
        end else begin
          bytes_left = bytes_left - 1'b1;
          if (!discard_mode) begin
            r.kind = hcbd_pkg::KIND_PAYLOAD;
            r.data = b;
          end
          if (bytes_left == 0) begin
            r.chunk_end = 1'b1;
            st = ST_LINE_END;
          end
        end
      end
      ST_LINE_END: begin
        if (b == hcbd_pkg::LF_CHAR) begin
          if (zero_chunk) begin
            r.kind = hcbd_pkg::KIND_DONE;
            zero_chunk = 1'b0;
          end
          st = ST_SIZE_LINE;
          digits_done = 1'b0;
          size_acc = '0;
          line_ovf = 1'b0;
        end
      end
      default: begin
        if (b == hcbd_pkg::LF_CHAR) begin
          r.ovf = line_ovf;
          zero_chunk = (size_acc == 0);
          bytes_left = size_acc;
          st = (size_acc == 0) ? ST_LINE_END : ST_PAYLOAD;
          digits_done = 1'b0;
          size_acc = '0;
          line_ovf = 1'b0;
        end else begin
          d = digits_done ? -1 : hex_digit(b);
          if (d < 0) begin
            digits_done = 1'b1;
          end else if (size_acc > (LEN_MAX >> 4)) begin
            size_acc = LEN_MAX;
            line_ovf = 1'b1;
          end else begin
            size_acc = (size_acc << 4) | hcbd_pkg::len_t'(d);
          end
          r.ovf = line_ovf;
        end
      end
    endcase
    return r;
  endfunction

  // keeps random traffic to chunk sizes of two hex digits at most
  function automatic logic [7:0] tame(input logic [7:0] b);
    if (st == ST_SIZE_LINE && !digits_done && size_acc >= 16 && hex_digit(b) >= 0)
      return ";";
    return b;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == hcbd_pkg::LF_CHAR) ? CR_CHAR : b;
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(48 + v);
    return ($urandom_range(0, 1) != 0) ? 8'(87 + v) : 8'(55 + v);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decoded_bytes.push_back(decode_byte(b));
    bytes_sent++;
  endtask

  task automatic send_guarded(input logic [7:0] b);
    send_byte(tame(b));
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_end();
    if ($urandom_range(0, 3) != 0) send_guarded(CR_CHAR);
    send_guarded(hcbd_pkg::LF_CHAR);
  endtask

  task automatic send_junk(input int n);
    int i;
    for (i = 0; i < n; i++) send_guarded(junk_byte());
  endtask

  task automatic send_size_line(input int size);
    int n_zeros;
    int i;
    n_zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : $urandom_range(0, 1);
    for (i = 0; i < n_zeros; i++) send_guarded("0");
    if (size >= 16) send_guarded(hex_char(size >> 4));
    send_guarded(hex_char(size & 15));
    // chunk extension, ignored up to the end of the line
    if ($urandom_range(0, 4) == 0) begin
      send_guarded(";");
      send_junk($urandom_range(0, 5));
    end
    send_line_end();
  endtask

  // broken: 1 short payload, 2 missing line after payload, 3 extra trailer line and blank line
  task automatic send_message(input bit broken);
    int n_chunks;
    int size;
    int n_pay;
    int flaw;
    int i;
    int j;
    n_chunks = $urandom_range(0, 3);
    flaw = broken ? $urandom_range(1, 3) : 0;
    for (i = 0; i < n_chunks; i++) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 47) : $urandom_range(1, 8);
      send_size_line(size);
      n_pay = (flaw == 1 && i == 0) ? $urandom_range(0, size - 1) : size;
      for (j = 0; j < n_pay; j++) send_guarded(8'($urandom_range(0, 255)));
      if (!(flaw == 2 && i == 0)) begin
        if ($urandom_range(0, 7) == 0) send_junk($urandom_range(1, 4));
        send_line_end();
      end
    end
    // last chunk: a zero, several zeros, an extension alone or an empty line
    case ($urandom_range(0, 3))
      0: send_guarded("0");
      1: begin
        n_pay = $urandom_range(2, 12);
        for (j = 0; j < n_pay; j++) send_guarded("0");
      end
      2: begin
        send_guarded(";");
        send_junk($urandom_range(0, 4));
      end
      default: ;
    endcase
    send_line_end();
    // one line follows the last chunk, trailer text included
    if ($urandom_range(0, 3) == 0) begin
      send_guarded("T");
      send_junk($urandom_range(0, 6));
    end
    send_line_end();
    if (flaw == 3) begin
      send_guarded("X");
      send_junk($urandom_range(0, 6));
      send_line_end();
      send_line_end();
    end
  endtask

  task automatic wait_all_decoded();
    in_ch.valid <= 1'b0;
    while (decoded_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_discard(input bit v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    discard_mode = v;
  endtask

  task automatic test_directed_framing();
    // single-byte chunk of 0x00, crlf endings
    send_text("1\015\n");
    send_byte(8'h00);
    send_text("\015\n");
    // extension, bare lf, 0xff and an lf inside the payload
    send_text("2;x\n");
    send_byte(8'hFF);
    send_byte(hcbd_pkg::LF_CHAR);
    send_text("\n");
    send_text("0\015\n\015\n");
    // non-hex before any digit reads as size zero
    send_text("z\n\n");
    wait_all_decoded();
  endtask

  task automatic test_random_traffic();
    int p;
    int stop_at;
    int pick;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_discard(1'b1);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          set_discard(1'b0);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          set_discard(1'($urandom_range(0, 1)));
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        default: begin
          set_discard(1'b0);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
      endcase
      stop_at = bytes_sent + 90;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) send_message(1'b0);
        else if (pick == 8) send_message(1'b1);
        else send_junk($urandom_range(1, 8));
      end
      wait_all_decoded();
    end
  endtask

  task automatic test_receiver_backpressure();
    int stop_at;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    rx_hold_len = 200;
    wait (rx_holding);
    stop_at = bytes_sent + 30;
    while (bytes_sent < stop_at) send_message(1'b0);
    wait_all_decoded();
    tx_idle = 1'b1;
  endtask

  // saturating size line; the chunk never ends, so this runs last
  task automatic test_size_overflow();
    int i;
    set_discard(1'b0);
    send_text("fffffffff;x\015\n");
    for (i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
    wait_all_decoded();
    set_discard(1'b1);
    for (i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
    wait_all_decoded();
  endtask

  // receiver side: random stalls, plus one long hold on request
  initial begin : rx_ready_gen
    int n;
    forever begin
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        rx_holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rx_holding = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_outputs
    decoded_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (decoded_bytes.size() == 0) begin
        $error("unexpected item: out_byte %0h kind %0d", out_ch.out_byte, out_ch.kind);
        n_errors++;
      end else begin
        want = decoded_bytes.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_ch.out_byte);
          n_errors++;
        end
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          n_errors++;
        end
        if (out_ch.chunk_last !== want.chunk_end) begin
          $error("chunk_last: expected %0b, got %0b", want.chunk_end, out_ch.chunk_last);
          n_errors++;
        end
        if (out_ch.size_overflow !== want.ovf) begin
          $error("size_overflow: expected %0b, got %0b", want.ovf, out_ch.size_overflow);
          n_errors++;
        end
        if (want.kind == hcbd_pkg::KIND_PAYLOAD) n_payload++;
        if (want.kind == hcbd_pkg::KIND_DONE) n_complete++;
        if (want.ovf) n_ovf++;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_data      <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_framing();
    test_random_traffic();
    test_receiver_backpressure();
    test_size_overflow();
    repeat (8) @(posedge clk);
    $display("%0d body bytes decoded: %0d payload bytes delivered, %0d messages completed",
             bytes_sent, n_payload, n_complete);
    $display("%0d items flagged size overflow; discard on and off, with and without stalls",
             n_ovf);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
sv/hcbd_pkg.sv
sv/hcbd_if.sv
sv/hcbd_in_reg.sv
sv/hcbd_core.sv
sv/http_chunked_body_decoder_unit.sv
tb/tb_http_chunked_body_decoder_unit.sv
